// ===== rtl/cfws_pkg.sv =====
// Package for the circular FIFO with search.
// Command codes, status codes and the control/status structs between the
// controller and the datapath. No dependencies.
`default_nettype none
package cfws_pkg;

  localparam int DEF_SLOTS = 8;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 3;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;

  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SRCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic start;     // input transfer taken this cycle
    logic capture;   // dequeue read data lands in result
    logic step;      // advance search to next entry
    logic hit;       // search match, latch position
    logic load_out;  // move result to output register
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/cfws_dp.sv =====
// Datapath of the circular FIFO with search: ring memory, head/tail
// indices, search pointer and counter, result and output registers.
// Depends on cfws_pkg.
`default_nettype none
module cfws_dp import cfws_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  ctl,
  output dp_stat_t                 st,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [DATA_W-1:0] value_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] data_out,
  output logic [POS_W-1:0]         position,
  output logic [STAT_W-1:0]        status,
  output logic                     is_empty,
  output logic                     is_full
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W+1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    next_slot = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  logic [DATA_W-1:0] mem [SLOTS];
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] key;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [IDX_W-1:0]  ptr;
  logic [IDX_W-1:0]  cnt;
  logic [DATA_W-1:0] res_data;
  logic [POS_W-1:0]  res_pos;
  logic [STAT_W-1:0] res_status;

  logic              empty;
  logic              full;
  logic [IDX_W:0]    diff;
  logic [IDX_W:0]    count;
  logic              we;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  tail_inc;

  assign head_inc = next_slot(head);
  assign tail_inc = next_slot(tail);
  assign empty    = (head == tail);
  assign full     = (tail_inc == head);
  assign diff     = {1'b0, tail} - {1'b0, head};
  assign count    = (tail >= head) ? diff : diff + SLOTS_X;

  assign we      = ctl.start && (cmd == CMD_ENQ) && !full;
  assign rd_en   = (ctl.start && !empty && (cmd == CMD_DEQ || cmd == CMD_SRCH)) || ctl.step;
  assign rd_addr = ctl.start ? head_inc : ptr;

  assign st.empty    = empty;
  assign st.hit      = (rd_data == key);
  assign st.last     = (cnt == count[IDX_W-1:0]);
  assign st.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[tail_inc] <= value_in;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (ctl.start) begin
      if (cmd == CMD_ENQ && !full) begin
        tail <= tail_inc;
      end
      if (cmd == CMD_DEQ && !empty) begin
        head <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      key      <= value_in;
      ptr      <= next_slot(head_inc);
      cnt      <= IDX_W'(1);
      res_data <= (cmd == CMD_DEQ && empty) ? '1 : '0;
      res_pos  <= '0;
      unique case (cmd)
        CMD_ENQ: begin
          res_status <= full ? ST_FULL : ST_OK;
        end
        CMD_DEQ: begin
          res_status <= empty ? ST_EMPTY : ST_OK;
        end
        CMD_SRCH: begin
          res_status <= ST_NOTFOUND;
        end
        default: begin
          res_status <= ST_OK;
        end
      endcase
    end
    if (ctl.capture) begin
      res_data <= rd_data;
    end
    if (ctl.step) begin
      ptr <= next_slot(ptr);
      cnt <= cnt + 1'b1;
    end
    if (ctl.hit) begin
      res_pos    <= POS_W'(cnt);
      res_status <= ST_OK;
    end
    if (ctl.load_out) begin
      data_out <= res_data;
      position <= res_pos;
      status   <= res_status;
      is_empty <= empty;
      is_full  <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_not_full_and_empty: assert property (@(posedge clk) disable iff (rst)
    !(empty && full))
    else $error("ring reports full and empty at once");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> ({1'b0, cnt} < count))
    else $error("search walked past newest entry");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> st.out_free)
    else $error("output register overwritten before transfer");

endmodule
`default_nettype wire

// ===== rtl/cfws_ctrl.sv =====
// Controller of the circular FIFO with search: sequences one command at a
// time through read, search walk and output hand-off. Depends on cfws_pkg.
`default_nettype none
module cfws_ctrl import cfws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] cmd,
  input  dp_stat_t         st,
  output dp_cmd_t          ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.start = 1'b1;
          unique case (cmd)
            CMD_DEQ:  state_next = st.empty ? S_DONE : S_RD;
            CMD_SRCH: state_next = st.empty ? S_DONE : S_SRCH;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_RD: begin
        ctl.capture = 1'b1;
        state_next  = S_DONE;
      end
      S_SRCH: begin
        priority if (st.hit) begin
          ctl.hit    = 1'b1;
          state_next = S_DONE;
        end else if (st.last) begin
          state_next = S_DONE;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctl))
    else $error("more than one datapath command at once");

  a_rd_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |=> (state == S_DONE))
    else $error("dequeue read did not finish");

  a_start_only_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> (state != S_IDLE))
    else $error("accepted command left no work");

endmodule
`default_nettype wire

// ===== rtl/circular_fifo_with_search_top.sv =====
// Circular FIFO with search, one command at a time. Output registered after
// the input transfer: from the done state for enqueue, empty dequeue, search on
// an empty ring and unused codes; after a read state for dequeue; after the
// search walk for a search (one memory read per cycle). Next input taken the
// cycle after the output loads, and a stalled output delays that load.
// Reset clears head, tail, controller and output valid; ring contents are not
// cleared and no clearing pass runs. Depends on cfws_pkg, cfws_ctrl, cfws_dp.
`default_nettype none
module circular_fifo_with_search_top import cfws_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [DATA_W-1:0] value_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] data_out,
  output logic [POS_W-1:0]         position,
  output logic [STAT_W-1:0]        status,
  output logic                     is_empty,
  output logic                     is_full
);

  dp_cmd_t  ctl;
  dp_stat_t st;

  cfws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st),
    .ctl      (ctl)
  );

  cfws_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .st        (st),
    .cmd       (cmd),
    .value_in  (value_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out),
    .position  (position),
    .status    (status),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

endmodule
`default_nettype wire

// ===== sim/circular_fifo_with_search_top_test.sv =====
// Self-checking testbench for circular_fifo_with_search_top: predicts every result of
// enqueue, dequeue, search and unused codes, and checks each result transfer under random idling and output stalls.
// Depends on cfws_pkg and the circular_fifo_with_search_top RTL.
`default_nettype none

typedef struct packed {
  logic signed [cfws_pkg::DATA_W-1:0] data;
  logic [cfws_pkg::POS_W-1:0]         pos;
  logic [cfws_pkg::STAT_W-1:0]        stat;
  logic                               empty;
  logic                               full;
} ring_result_t;

class ring_model;
  logic signed [cfws_pkg::DATA_W-1:0] ring [cfws_pkg::DEF_SLOTS];
  int unsigned head;
  int unsigned tail;
  ring_result_t expected_results [$];
  int errors;
  int checked;
  int cmd_count [4];
  int full_rejects;
  int empty_reads;
  int search_hits;
  int search_misses;

  function new();
    head = 0;
    tail = 0;
    errors = 0;
    checked = 0;
    full_rejects = 0;
    empty_reads = 0;
    search_hits = 0;
    search_misses = 0;
    foreach (cmd_count[k]) cmd_count[k] = 0;
  endfunction

  function int unsigned next_slot(int unsigned i);
    return (i + 1) % cfws_pkg::DEF_SLOTS;
  endfunction

  function bit ring_empty();
    return head == tail;
  endfunction

  function bit ring_full();
    return next_slot(tail) == head;
  endfunction

  function int unsigned occupancy();
    return (tail + cfws_pkg::DEF_SLOTS - head) % cfws_pkg::DEF_SLOTS;
  endfunction

  function logic signed [cfws_pkg::DATA_W-1:0] stored_entry(int unsigned k);
    return ring[(head + 1 + k) % cfws_pkg::DEF_SLOTS];
  endfunction

  function void predict(logic [cfws_pkg::CMD_W-1:0] c, logic signed [cfws_pkg::DATA_W-1:0] v);
    ring_result_t r;
    int unsigned i;
    int unsigned n;
    r = '0;
    cmd_count[c]++;
    case (c)
      cfws_pkg::CMD_ENQ: begin
        if (ring_full()) begin
          r.stat = cfws_pkg::ST_FULL;
          full_rejects++;
        end else begin
          tail = next_slot(tail);
          ring[tail] = v;
        end
      end
      cfws_pkg::CMD_DEQ: begin
        if (ring_empty()) begin
          r.data = -1;
          r.stat = cfws_pkg::ST_EMPTY;
          empty_reads++;
        end else begin
          head = next_slot(head);
          r.data = ring[head];
        end
      end
      cfws_pkg::CMD_SRCH: begin
        r.stat = cfws_pkg::ST_NOTFOUND;
        i = head;
        n = 0;
        while (i != tail && r.stat != cfws_pkg::ST_OK) begin
          i = next_slot(i);
          n++;
          if (ring[i] == v) begin
            r.pos = n[cfws_pkg::POS_W-1:0];
            r.stat = cfws_pkg::ST_OK;
          end
        end
        if (r.stat == cfws_pkg::ST_OK) search_hits++;
        else search_misses++;
      end
      default: ;
    endcase
    r.empty = ring_empty();
    r.full = ring_full();
    expected_results.push_back(r);
  endfunction

  task report(string msg);
    if (errors < 40) $display("ERROR: %s", msg);
    errors++;
  endtask

  task check_result(ring_result_t got);
    ring_result_t exp;
    if (expected_results.size() == 0) begin
      report($sformatf("result transfer with nothing pending: data %0d", got.data));
    end else begin
      exp = expected_results.pop_front();
      checked++;
      if (got.data !== exp.data)
        report($sformatf("result %0d data_out %0d, want %0d", checked, got.data, exp.data));
      if (got.pos !== exp.pos)
        report($sformatf("result %0d position %0d, want %0d", checked, got.pos, exp.pos));
      if (got.stat !== exp.stat)
        report($sformatf("result %0d status %0d, want %0d", checked, got.stat, exp.stat));
      if (got.empty !== exp.empty)
        report($sformatf("result %0d is_empty %b, want %b", checked, got.empty, exp.empty));
      if (got.full !== exp.full)
        report($sformatf("result %0d is_full %b, want %b", checked, got.full, exp.full));
    end
  endtask
endclass

module circular_fifo_with_search_top_test;
  import cfws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int MODE_FILL = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] value_in;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] data_out;
  logic [POS_W-1:0]         position;
  logic [STAT_W-1:0]        status;
  logic                     is_empty;
  logic                     is_full;

  int idle_pct;
  int stall_pct;
  ring_model model = new();

  circular_fifo_with_search_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .value_in(value_in),
    .out_valid(out_valid), .out_stall(out_stall), .data_out(data_out),
    .position(position), .status(status), .is_empty(is_empty), .is_full(is_full)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_ENQ;
    value_in = '0;
    out_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      model.check_result('{data: data_out, pos: position, stat: status,
                           empty: is_empty, full: is_full});
  end

  task send_cmd(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 12) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    value_in <= v;
    do @(posedge clk); while (in_stall);
    model.predict(c, v);
  endtask

  function logic signed [DATA_W-1:0] random_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(7);
    if (r < 80) return $urandom;
    case ($urandom_range(3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -1;
      default: return 0;
    endcase
  endfunction

  task run_random(input int count);
    int mode;
    int r;
    int enq_lim;
    int deq_lim;
    logic [CMD_W-1:0] c;
    logic signed [DATA_W-1:0] v;
    mode = MODE_MIXED;
    for (int k = 0; k < count; k++) begin
      if (k % 20 == 0) mode = $urandom_range(2);
      case (mode)
        MODE_FILL:  begin enq_lim = 60; deq_lim = 80; end
        MODE_DRAIN: begin enq_lim = 20; deq_lim = 65; end
        default:    begin enq_lim = 35; deq_lim = 70; end
      endcase
      r = $urandom_range(99);
      if (r < 3) c = CMD_NOP;
      else if (r < enq_lim) c = CMD_ENQ;
      else if (r < deq_lim) c = CMD_DEQ;
      else c = CMD_SRCH;
      if (c == CMD_SRCH && model.occupancy() > 0 && $urandom_range(99) < 60)
        v = model.stored_entry($urandom_range(model.occupancy() - 1));
      else
        v = random_value();
      send_cmd(c, v);
    end
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty ring corner cases
    send_cmd(CMD_SRCH, 0);
    send_cmd(CMD_DEQ, 32'sh7fff_ffff);
    send_cmd(CMD_NOP, -1);
    // fill to capacity with the value extremes, then one enqueue past full
    send_cmd(CMD_ENQ, 32'sh8000_0000);
    send_cmd(CMD_ENQ, 32'sh7fff_ffff);
    send_cmd(CMD_ENQ, -1);
    send_cmd(CMD_ENQ, 0);
    send_cmd(CMD_ENQ, 5);
    send_cmd(CMD_ENQ, 6);
    send_cmd(CMD_ENQ, 7);
    send_cmd(CMD_ENQ, 9);
    send_cmd(CMD_SRCH, 32'sh8000_0000);
    send_cmd(CMD_SRCH, 7);
    send_cmd(CMD_SRCH, 12345);
    send_cmd(CMD_NOP, 0);
    // wrap the indices, then search across the wrap
    send_cmd(CMD_DEQ, 0);
    send_cmd(CMD_DEQ, 0);
    send_cmd(CMD_ENQ, 11);
    send_cmd(CMD_ENQ, 12);
    send_cmd(CMD_SRCH, 12);
    send_cmd(CMD_SRCH, -1);
    repeat (7) send_cmd(CMD_DEQ, 0);
    send_cmd(CMD_DEQ, 0);

    idle_pct = 0;  stall_pct = 0;  run_random(130);
    idle_pct = 46; stall_pct = 0;  run_random(130);
    idle_pct = 0;  stall_pct = 46; run_random(130);
    idle_pct = 36; stall_pct = 36; run_random(130);

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (model.expected_results.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (model.expected_results.size() > 0)
      model.report($sformatf("%0d results never arrived", model.expected_results.size()));

    $display("Run covered %0d enqueues, %0d dequeues, %0d searches, %0d unused codes;",
             model.cmd_count[CMD_ENQ], model.cmd_count[CMD_DEQ], model.cmd_count[CMD_SRCH],
             model.cmd_count[CMD_NOP]);
    $display("%0d results checked; full rejects %0d, empty dequeues %0d, hits %0d, misses %0d",
             model.checked, model.full_rejects, model.empty_reads, model.search_hits,
             model.search_misses);
    if (model.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

`default_nettype wire
